### hdl/vtts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtts_pkg
// Shared types and codes for the volume texture trilinear sampler.
// ----------------------------------------------------------------------------
package vtts_pkg;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_FETCH  = 2'd1,
    OP_SAMPLE = 2'd2
  } op_t;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_DEPTH  = 2'd2;

  localparam int FRAC_BITS = 16;
  localparam int CFG_BITS  = 6;

  // tag carried with every item from front to back
  typedef struct packed {
    op_t  op;
    logic in_range;
  } item_ctl_t;

  localparam int CTL_BITS = $bits(item_ctl_t);

endpackage

### hdl/vtts_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtts_front
// Size registers, range check and coordinate scaling of incoming items.
// ----------------------------------------------------------------------------
module vtts_front #(
  parameter int MAX_DIM    = 32,
  parameter int TEXEL_BITS = 16,
  parameter int CW         = $clog2(MAX_DIM + 1),
  parameter int SW         = CW + 17
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  input  logic [1:0]              cfg_index,
  input  logic [5:0]              cfg_data,
  input  logic                    start,
  input  logic                    full,
  input  logic [1:0]              in_operation,
  input  logic signed [15:0]      in_texel_x,
  input  logic signed [15:0]      in_texel_y,
  input  logic signed [15:0]      in_texel_z,
  input  logic signed [17:0]      in_u_coord,
  input  logic signed [17:0]      in_v_coord,
  input  logic signed [17:0]      in_w_coord,
  input  logic [15:0]             in_write_value,
  output logic                    push,
  output vtts_pkg::item_ctl_t     ctl,
  output logic signed [SW-1:0]    scaled [3],
  output logic [TEXEL_BITS-1:0]   wdata,
  output logic [CW-1:0]           dim [3]
);
  import vtts_pkg::*;

  logic [CFG_BITS-1:0] size_r [3];
  logic [CFG_BITS-1:0] size_nxt [3];
  logic signed [15:0]  pt [3];
  logic signed [17:0]  nc [3];
  logic                pt_ok, nc_ok;
  logic [15+CW:0]      prod [3];
  op_t                 op;

  always_comb begin
    size_nxt = size_r;
    if (cfg_valid) begin
      if (cfg_index == CFG_WIDTH)  size_nxt[0] = cfg_data;
      if (cfg_index == CFG_HEIGHT) size_nxt[1] = cfg_data;
      if (cfg_index == CFG_DEPTH)  size_nxt[2] = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) size_r[a] <= CFG_BITS'(32);
    end else begin
      size_r <= size_nxt;
    end
  end

  // zero acts as one, anything beyond the store as the store size
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (size_r[a] == '0)               dim[a] = CW'(1);
      else if (int'(size_r[a]) > MAX_DIM) dim[a] = CW'(MAX_DIM);
      else                                dim[a] = CW'(size_r[a]);
    end
  end

  assign pt[0] = in_texel_x;
  assign pt[1] = in_texel_y;
  assign pt[2] = in_texel_z;
  assign nc[0] = in_u_coord;
  assign nc[1] = in_v_coord;
  assign nc[2] = in_w_coord;
  assign op    = op_t'(in_operation);

  always_comb begin
    pt_ok = 1'b1;
    nc_ok = 1'b1;
    for (int a = 0; a < 3; a++) begin
      if (pt[a][15] || (pt[a][15:0] >= 16'(dim[a]))) pt_ok = 1'b0;
      if (nc[a][17] || nc[a][16]) nc_ok = 1'b0;
      prod[a] = (16+CW)'(nc[a][15:0]) * (16+CW)'(dim[a]);
      if (op == OP_SAMPLE)
        scaled[a] = $signed({1'b0, prod[a]}) - SW'(32768);
      else
        scaled[a] = $signed({1'b0, pt[a][CW-1:0], 16'h0000});
    end
  end

  always_comb begin
    ctl.op = op;
    unique case (op)
      OP_WRITE, OP_FETCH: ctl.in_range = pt_ok;
      OP_SAMPLE:          ctl.in_range = nc_ok;
      default:            ctl.in_range = 1'b0;
    endcase
  end

  assign wdata = TEXEL_BITS'(in_write_value);
  assign push  = start && !full;

endmodule

### hdl/vtts_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtts_queue
// Two-entry item queue between the front and the back.
// ----------------------------------------------------------------------------
module vtts_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);
  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

### hdl/vtts_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtts_back
// Banked texel store, neighbor read and three blend stages.
// ----------------------------------------------------------------------------
module vtts_back #(
  parameter int MAX_DIM    = 32,
  parameter int TEXEL_BITS = 16,
  parameter int CW         = $clog2(MAX_DIM + 1),
  parameter int SW         = CW + 17
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    empty,
  output logic                    pop,
  input  vtts_pkg::item_ctl_t     ctl,
  input  logic signed [SW-1:0]    scaled [3],
  input  logic [TEXEL_BITS-1:0]   wdata,
  input  logic [CW-1:0]           dim [3],
  output logic                    out_strobe,
  output logic [15:0]             out_sample_value,
  output logic                    out_in_range
);
  import vtts_pkg::*;

  localparam int TB    = TEXEL_BITS;
  localparam int HW    = (MAX_DIM > 2) ? $clog2(MAX_DIM) - 1 : 1;
  localparam int AW    = 3 * HW;
  localparam int BDEPTH = 1 << AW;

  function automatic logic [TB-1:0] blend(input logic [TB-1:0] a,
                                          input logic [TB-1:0] b,
                                          input logic [15:0]   f);
    logic signed [TB:0]    d;
    logic signed [TB+17:0] p;
    logic signed [TB+17:0] q;
    d = $signed({1'b0, b}) - $signed({1'b0, a});
    p = (TB+18)'(d) * (TB+18)'($signed({1'b0, f}));
    q = p >>> 16;
    return TB'(q + $signed((TB+18)'(a)));
  endfunction

  function automatic logic [HW-1:0] half(input logic [CW-1:0] c);
    return HW'(c >> 1);
  endfunction

  // split stage
  logic [CW-1:0] ip [3], i0 [3], i1 [3], lim [3];
  logic [15:0]   fr [3];
  logic [CW-1:0] cp [3][2];
  logic [AW-1:0] raddr [8];
  logic [AW-1:0] waddr;
  logic [7:0]    we;
  logic [2:0]    wbank;

  assign pop = !empty;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      lim[a] = dim[a] - CW'(1);
      if (scaled[a][SW-1]) begin
        ip[a] = '0;
        fr[a] = '0;
      end else begin
        ip[a] = scaled[a][SW-2:FRAC_BITS];
        fr[a] = scaled[a][FRAC_BITS-1:0];
      end
      i0[a] = (ip[a] > lim[a]) ? lim[a] : ip[a];
      i1[a] = (ctl.op == OP_SAMPLE && i0[a] < lim[a]) ? i0[a] + CW'(1) : i0[a];
      // bank of parity p reads whichever neighbor has that parity
      for (int p = 0; p < 2; p++)
        cp[a][p] = (i0[a][0] == p[0]) ? i0[a] : i1[a];
    end
    for (int b = 0; b < 8; b++)
      raddr[b] = {half(cp[2][b/4]), half(cp[1][(b/2)%2]), half(cp[0][b%2])};
    waddr = {half(i0[2]), half(i0[1]), half(i0[0])};
    wbank = {i0[2][0], i0[1][0], i0[0][0]};
    for (int b = 0; b < 8; b++)
      we[b] = pop && ctl.op == OP_WRITE && ctl.in_range && (wbank == 3'(b));
  end

  logic [TB-1:0] rd_r [8];

  for (genvar g = 0; g < 8; g++) begin : g_bank
    logic [TB-1:0] mem [BDEPTH];
    always_ff @(posedge clk) begin
      if (we[g]) mem[waddr] <= wdata;
      rd_r[g] <= mem[raddr[g]];
    end
  end

  // stage 1: neighbors read
  logic            v1_r;
  item_ctl_t       ctl1_r;
  logic [2:0]      par0_r, par1_r;
  logic [15:0]     f1_r [3];
  // stage 2: x blended
  logic            v2_r;
  item_ctl_t       ctl2_r;
  logic [15:0]     fy2_r, fz2_r;
  logic [TB-1:0]   t_r [4];
  logic [TB-1:0]   t_nxt [4];
  // stage 3: y blended
  logic            v3_r;
  item_ctl_t       ctl3_r;
  logic [15:0]     fz3_r;
  logic [TB-1:0]   u_r [2];
  logic [TB-1:0]   r_nxt;

  always_comb begin
    logic [2:0] ba, bb;
    for (int k = 0; k < 4; k++) begin
      // k[1] picks y neighbor, k[0] picks z neighbor
      ba = {k[0] ? par1_r[2] : par0_r[2], k[1] ? par1_r[1] : par0_r[1], par0_r[0]};
      bb = {k[0] ? par1_r[2] : par0_r[2], k[1] ? par1_r[1] : par0_r[1], par1_r[0]};
      t_nxt[k] = blend(rd_r[ba], rd_r[bb], f1_r[0]);
    end
    r_nxt = blend(u_r[0], u_r[1], fz3_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
      out_strobe <= 1'b0;
    end else begin
      v1_r       <= pop;
      v2_r       <= v1_r;
      v3_r       <= v2_r;
      out_strobe <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    ctl1_r <= ctl;
    par0_r <= {i0[2][0], i0[1][0], i0[0][0]};
    par1_r <= {i1[2][0], i1[1][0], i1[0][0]};
    f1_r   <= fr;
    ctl2_r <= ctl1_r;
    fy2_r  <= f1_r[1];
    fz2_r  <= f1_r[2];
    t_r    <= t_nxt;
    ctl3_r <= ctl2_r;
    fz3_r  <= fz2_r;
    u_r[0] <= blend(t_r[0], t_r[2], fy2_r);
    u_r[1] <= blend(t_r[1], t_r[3], fy2_r);
    out_in_range     <= ctl3_r.in_range;
    out_sample_value <= (ctl3_r.in_range && ctl3_r.op != OP_WRITE) ? 16'(r_nxt) : 16'h0000;
  end

  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(pop, 4))
    else $error("result without a popped item four cycles before");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_in_range |-> out_sample_value == 16'h0000)
    else $error("nonzero value for out-of-range item");

  a_one_bank: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(we))
    else $error("more than one bank written");

  a_no_stray_wr: assert property (@(posedge clk) disable iff (!rst_n)
    (we != 8'h00) |-> (pop && ctl.op == OP_WRITE && ctl.in_range))
    else $error("store written for an item that is no valid write");

endmodule

### hdl/volume_texture_trilinear_sampler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// volume_texture_trilinear_sampler_unit
// 3D texel volume with write, point fetch and trilinear sample.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  in_       start / busy         in_operation, in_texel_x/y/z, in_u/v/w_coord,
//                                 in_write_value
//  out_      out_strobe           out_sample_value, out_in_range
//  cfg_      cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  One item per cycle. Five register stages: queue, banked store read,
//  x blend, y blend, z blend; out_strobe rises with the registered z blend result.
//  Eight store banks split by coordinate parity serve all neighbors at once.
//  Reset: sizes go to 32, queue and pipeline empty; the store is not cleared.
//  The back pops whenever the queue holds an item, so the two-entry queue never fills and busy
//  stays low; results are never held.
// ----------------------------------------------------------------------------
module volume_texture_trilinear_sampler_unit #(
  parameter int MAX_DIM    = 32,
  parameter int TEXEL_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_operation,
  input  logic signed [15:0] in_texel_x,
  input  logic signed [15:0] in_texel_y,
  input  logic signed [15:0] in_texel_z,
  input  logic signed [17:0] in_u_coord,
  input  logic signed [17:0] in_v_coord,
  input  logic signed [17:0] in_w_coord,
  input  logic [15:0]        in_write_value,
  output logic               out_strobe,
  output logic [15:0]        out_sample_value,
  output logic               out_in_range,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [5:0]         cfg_data
);
  import vtts_pkg::*;

  localparam int CW = $clog2(MAX_DIM + 1);
  localparam int SW = CW + 17;
  localparam int QW = CTL_BITS + 3 * SW + TEXEL_BITS;

  logic                    push, pop, full, empty;
  item_ctl_t               f_ctl, b_ctl;
  logic signed [SW-1:0]    f_scaled [3], b_scaled [3];
  logic [TEXEL_BITS-1:0]   f_wdata, b_wdata;
  logic [CW-1:0]           dim [3];
  logic [QW-1:0]           q_in, q_out;

  assign cfg_ready = 1'b1;
  assign busy      = full;

  vtts_front #(.MAX_DIM(MAX_DIM), .TEXEL_BITS(TEXEL_BITS), .CW(CW), .SW(SW)) u_front (
    .clk, .rst_n, .cfg_valid, .cfg_index, .cfg_data, .start, .full,
    .in_operation, .in_texel_x, .in_texel_y, .in_texel_z,
    .in_u_coord, .in_v_coord, .in_w_coord, .in_write_value,
    .push, .ctl(f_ctl), .scaled(f_scaled), .wdata(f_wdata), .dim
  );

  assign q_in = {f_ctl, f_scaled[2], f_scaled[1], f_scaled[0], f_wdata};
  assign {b_ctl, b_scaled[2], b_scaled[1], b_scaled[0], b_wdata} = q_out;

  vtts_queue #(.WIDTH(QW)) u_queue (
    .clk, .rst_n, .push, .wr_data(q_in), .pop, .rd_data(q_out), .full, .empty
  );

  vtts_back #(.MAX_DIM(MAX_DIM), .TEXEL_BITS(TEXEL_BITS), .CW(CW), .SW(SW)) u_back (
    .clk, .rst_n, .empty, .pop, .ctl(b_ctl), .scaled(b_scaled), .wdata(b_wdata), .dim,
    .out_strobe, .out_sample_value, .out_in_range
  );

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the volume texture trilinear sampler: writes,
// point fetches and trilinear samples under several volume sizes, compared
// against an in-bench texel volume and blend predictor.
// ----------------------------------------------------------------------------
module testbench;
  import vtts_pkg::*;

  typedef struct {
    logic [1:0]         op;
    logic signed [15:0] tx, ty, tz;
    logic signed [17:0] cu, cv, cw;
    logic [15:0]        wval;
  } texel_req_t;

  typedef struct {
    logic [15:0] value;
    logic        hit;
  } texel_resp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_operation = '0;
  logic signed [15:0] in_texel_x = '0, in_texel_y = '0, in_texel_z = '0;
  logic signed [17:0] in_u_coord = '0, in_v_coord = '0, in_w_coord = '0;
  logic [15:0] in_write_value = '0;
  logic out_strobe;
  logic [15:0] out_sample_value;
  logic out_in_range;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [5:0] cfg_data = '0;

  volume_texture_trilinear_sampler_unit u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [15:0] vol_texels [0:32767];
  bit          vol_written [0:32767];
  int unsigned dim_x = 32, dim_y = 32, dim_z = 32;

  texel_req_t  pending_items[$];
  texel_resp_t expected_texels[$];
  int unsigned n_errors = 0, n_checked = 0, n_samples = 0;
  bit pause_sender = 1'b0;
  int burst_left = 0, gap_left = 0;

  function automatic int unsigned clamp_dim(int unsigned r);
    if (r < 1) return 1;
    if (r > 32) return 32;
    return r;
  endfunction

  function automatic int unsigned texel_addr(int unsigned x, y, z);
    return (z * 32 + y) * 32 + x;
  endfunction

  function automatic longint lerp_q16(longint a, longint b, longint f);
    return a + ((b - a) * f >>> 16);
  endfunction

  function automatic void split_coord(longint c, int unsigned sz, output int unsigned i0,
                                      output int unsigned i1, output longint f);
    longint s;
    s = c * sz - 32768;
    if (s < 0) s = 0;
    i0 = s / 65536;
    f  = s % 65536;
    if (i0 > sz - 1) i0 = sz - 1;
    i1 = (i0 < sz - 1) ? i0 + 1 : i0;
  endfunction

  function automatic texel_resp_t predict_texel(texel_req_t r);
    texel_resp_t res;
    int unsigned w, h, d, x0, x1, y0, y1, z0, z1;
    longint fx, fy, fz, t0, t1, t2, t3, t02, t13, acc;
    res.value = '0;
    res.hit = 1'b0;
    w = clamp_dim(dim_x); h = clamp_dim(dim_y); d = clamp_dim(dim_z);
    if (r.op == OP_WRITE || r.op == OP_FETCH) begin
      if (r.tx >= 0 && r.tx < w && r.ty >= 0 && r.ty < h && r.tz >= 0 && r.tz < d) begin
        res.hit = 1'b1;
        if (r.op == OP_WRITE) begin
          vol_texels[texel_addr(r.tx, r.ty, r.tz)] = r.wval;
          vol_written[texel_addr(r.tx, r.ty, r.tz)] = 1'b1;
        end else begin
          res.value = vol_texels[texel_addr(r.tx, r.ty, r.tz)];
        end
      end
    end else if (r.op == OP_SAMPLE) begin
      if (r.cu >= 0 && r.cu < 65536 && r.cv >= 0 && r.cv < 65536 &&
          r.cw >= 0 && r.cw < 65536) begin
        split_coord(r.cu, w, x0, x1, fx);
        split_coord(r.cv, h, y0, y1, fy);
        split_coord(r.cw, d, z0, z1, fz);
        t0 = lerp_q16(vol_texels[texel_addr(x0, y0, z0)], vol_texels[texel_addr(x1, y0, z0)], fx);
        t1 = lerp_q16(vol_texels[texel_addr(x0, y0, z1)], vol_texels[texel_addr(x1, y0, z1)], fx);
        t2 = lerp_q16(vol_texels[texel_addr(x0, y1, z0)], vol_texels[texel_addr(x1, y1, z0)], fx);
        t3 = lerp_q16(vol_texels[texel_addr(x0, y1, z1)], vol_texels[texel_addr(x1, y1, z1)], fx);
        t02 = lerp_q16(t0, t2, fy);
        t13 = lerp_q16(t1, t3, fy);
        acc = lerp_q16(t02, t13, fz);
        if (acc < 0) acc = 0;
        res.value = acc[15:0];
        res.hit = 1'b1;
        n_samples++;
      end
    end
    return res;
  endfunction

  // driver: bursts and gaps; the front item is accepted when start && !busy
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        expected_texels.push_back(predict_texel(pending_items.pop_front()));
      end
      if (start && busy) begin
        // hold the item
      end else if (pending_items.size() > 0 && !pause_sender &&
                   (burst_left > 0 || gap_left == 0) &&
                   !(start && !busy && pending_items.size() == 0)) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        burst_left--;
        start          <= 1'b1;
        in_operation   <= pending_items[0].op;
        in_texel_x     <= pending_items[0].tx;
        in_texel_y     <= pending_items[0].ty;
        in_texel_z     <= pending_items[0].tz;
        in_u_coord     <= pending_items[0].cu;
        in_v_coord     <= pending_items[0].cv;
        in_w_coord     <= pending_items[0].cw;
        in_write_value <= pending_items[0].wval;
      end else begin
        if (gap_left > 0 && burst_left == 0) gap_left--;
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    texel_resp_t exp_r;
    if (rst_n && out_strobe) begin
      if (expected_texels.size() == 0) begin
        $display("%0t: unexpected result value=%h in_range=%b", $time,
                 out_sample_value, out_in_range);
        n_errors++;
      end else begin
        exp_r = expected_texels.pop_front();
        n_checked++;
        if (out_sample_value !== exp_r.value) begin
          $display("%0t: sample_value expected %h actual %h", $time, exp_r.value,
                   out_sample_value);
          n_errors++;
        end
        if (out_in_range !== exp_r.hit) begin
          $display("%0t: in_range expected %b actual %b", $time, exp_r.hit, out_in_range);
          n_errors++;
        end
      end
    end
  end

  function automatic texel_req_t make_req(logic [1:0] op, int x, y, z, int u, v, w,
                                          logic [15:0] val);
    texel_req_t r;
    r.op = op; r.tx = x; r.ty = y; r.tz = z;
    r.cu = u; r.cv = v; r.cw = w; r.wval = val;
    return r;
  endfunction

  // random in-volume write with random noise in the unused fields
  function automatic texel_req_t rand_write_in();
    return make_req(OP_WRITE, $urandom_range(0, clamp_dim(dim_x) - 1),
                    $urandom_range(0, clamp_dim(dim_y) - 1),
                    $urandom_range(0, clamp_dim(dim_z) - 1),
                    $urandom, $urandom, $urandom, $urandom);
  endfunction

  task automatic wait_drained();
    while (pending_items.size() > 0 || start || expected_texels.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_size(logic [1:0] idx, logic [5:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_WIDTH:  dim_x = val;
      CFG_HEIGHT: dim_y = val;
      default:    dim_z = val;
    endcase
    @(posedge clk);
  endtask

  // fill the whole active volume so every sample and fetch reads written texels
  task automatic fill_volume(bit extremes);
    for (int z = 0; z < clamp_dim(dim_z); z++)
      for (int y = 0; y < clamp_dim(dim_y); y++)
        for (int x = 0; x < clamp_dim(dim_x); x++)
          if (!vol_written[texel_addr(x, y, z)] || $urandom_range(0, 3) == 0)
            pending_items.push_back(make_req(OP_WRITE, x, y, z, $urandom, $urandom,
              $urandom, extremes ? (($urandom_range(0, 1)) ? 16'hFFFF : 16'h0000) : $urandom));
  endtask

  task automatic random_phase(int count);
    texel_req_t r;
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 20) begin
        r = rand_write_in();
      end else if (sel < 30) begin
        r = make_req(OP_WRITE, $signed(16'($urandom)), $signed(16'($urandom)),
                     $signed(16'($urandom)), $urandom, $urandom, $urandom, $urandom);
        if (r.tx >= 0 && r.tx < clamp_dim(dim_x) && r.ty >= 0 && r.ty < clamp_dim(dim_y) &&
            r.tz >= 0 && r.tz < clamp_dim(dim_z)) r.tx = -1;
      end else if (sel < 45) begin
        r = make_req(OP_FETCH, $urandom_range(0, clamp_dim(dim_x) - 1),
                     $urandom_range(0, clamp_dim(dim_y) - 1),
                     $urandom_range(0, clamp_dim(dim_z) - 1),
                     $urandom, $urandom, $urandom, $urandom);
      end else if (sel < 52) begin
        r = make_req(OP_FETCH, $signed(16'($urandom)), -$urandom_range(1, 40),
                     $urandom_range(32, 32767), $urandom, $urandom, $urandom, $urandom);
      end else if (sel < 85) begin
        r = make_req(OP_SAMPLE, $urandom, $urandom, $urandom, $urandom_range(0, 65535),
                     $urandom_range(0, 65535), $urandom_range(0, 65535), $urandom);
      end else if (sel < 95) begin
        r = make_req(OP_SAMPLE, $urandom, $urandom, $urandom, $signed(18'($urandom)),
                     $signed(18'($urandom)), $signed(18'($urandom)), $urandom);
      end else begin
        r = make_req(2'd3, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom);
      end
      pending_items.push_back(r);
    end
  endtask

  initial begin
    int sizes [5][3] = '{'{32, 32, 32}, '{1, 1, 1}, '{5, 2, 7}, '{0, 63, 3}, '{2, 32, 1}};
    for (int i = 0; i < 32768; i++) begin
      vol_texels[i] = '0;
      vol_written[i] = 1'b0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: small volume, extreme texels, corners, out-of-range codes
    write_size(CFG_WIDTH, 6'd2);
    write_size(CFG_HEIGHT, 6'd2);
    write_size(CFG_DEPTH, 6'd2);
    fill_volume(1'b1);
    pending_items.push_back(make_req(OP_FETCH, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_req(OP_FETCH, 1, 1, 1, 0, 0, 0, 0));
    pending_items.push_back(make_req(OP_FETCH, 2, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_req(OP_FETCH, -32768, 32767, 0, 0, 0, 0, 0));
    pending_items.push_back(make_req(OP_WRITE, 32767, -1, 0, 0, 0, 0, 16'hFFFF));
    pending_items.push_back(make_req(OP_SAMPLE, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_req(OP_SAMPLE, 0, 0, 0, 65535, 65535, 65535, 0));
    pending_items.push_back(make_req(OP_SAMPLE, 0, 0, 0, 65536, 0, 0, 0));
    pending_items.push_back(make_req(OP_SAMPLE, 0, 0, 0, -1, 0, 0, 0));
    pending_items.push_back(make_req(OP_SAMPLE, 0, 0, 0, 0, -131072, 131071, 0));
    pending_items.push_back(make_req(OP_SAMPLE, 0, 0, 0, 16383, 32768, 49152, 0));
    pending_items.push_back(make_req(2'd3, -1, -1, -1, -1, -1, -1, 16'hFFFF));
    wait_drained();

    foreach (sizes[s]) begin
      write_size(CFG_WIDTH, 6'(sizes[s][0]));
      write_size(CFG_HEIGHT, 6'(sizes[s][1]));
      write_size(CFG_DEPTH, 6'(sizes[s][2]));
      if (clamp_dim(dim_x) * clamp_dim(dim_y) * clamp_dim(dim_z) <= 400) fill_volume(1'b0);
      else begin
        // large volume: fill only a small corner and keep fetches and samples there
        for (int z = 0; z < 4; z++) for (int y = 0; y < 4; y++) for (int x = 0; x < 4; x++)
          pending_items.push_back(make_req(OP_WRITE, x, y, z, 0, 0, 0, $urandom));
        for (int i = 0; i < 60; i++)
          pending_items.push_back(make_req(i % 2 ? OP_FETCH : OP_SAMPLE,
            $urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3),
            $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095),
            $urandom));
        wait_drained();
        continue;
      end
      random_phase(80);
      if (s == 2) begin
        // sender holds off until every result is back
        while (pending_items.size() > 60) @(posedge clk);
        pause_sender = 1'b1;
        while (start || expected_texels.size() > 0) @(posedge clk);
        repeat (3) @(posedge clk);
        pause_sender = 1'b0;
      end
      wait_drained();
    end

    $display("checked %0d results, %0d in-volume trilinear samples, five volume shapes",
             n_checked, n_samples);
    if (n_errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

endmodule

### volume_texture_trilinear_sampler_unit.f
hdl/vtts_pkg.sv
hdl/vtts_front.sv
hdl/vtts_queue.sv
hdl/vtts_back.sv
hdl/volume_texture_trilinear_sampler_unit.sv
tb/testbench.sv
